/* rtl/krs_pkg.sv */
`timescale 1ns / 1ps
package krs_pkg;

	localparam int MemWords   = 2048;
	localparam int MemAw      = $clog2(MemWords);
	localparam int StageWords = 64;
	localparam int StageAw    = $clog2(StageWords);
	localparam logic [11:0] START_W   = 12'd5;
	localparam logic [9:0]  MAX_LEN   = 10'd512;
	localparam logic [14:0] CAP_RESET = 15'd10000;
	localparam logic [14:0] MEM_BYTES = 15'd16384;
	localparam logic [14:0] START_B   = 15'd40;

	typedef enum logic [1:0] {
		ACT_PUT = 2'd0,
		ACT_GET = 2'd1,
		ACT_HAS = 2'd2,
		ACT_REM = 2'd3
	} krs_act_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_MISS    = 2'd1,
		ST_NOSPACE = 2'd2,
		ST_WORD    = 2'd3
	} krs_status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SRCH, S_SKEY, S_SSTR, S_HLEN, S_HSTR, S_COPY,
		S_CHK, S_WHDR, S_WPAY, S_GRD, S_GOUT, S_EMIT
	} krs_state_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [63:0] key;
		logic [9:0]  len;
		logic [63:0] word;
		logic        last;
	} krs_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] word;
		logic [9:0]  len;
		logic        last;
	} krs_rsp_t;

	typedef struct packed {
		logic        idle;
		logic [11:0] end_w;
		logic [14:0] free_b;
		logic [14:0] cap_b;
	} krs_mon_t;

endpackage

/* rtl/krs_ram.sv */
`timescale 1ns / 1ps
module krs_ram #(
	parameter int Depth = 2048,
	parameter int Width = 64,
	localparam int Aw = $clog2(Depth)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [Aw-1:0]    waddr,
	input  logic [Width-1:0] wdata,
	input  logic             re,
	input  logic [Aw-1:0]    raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port, holds while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/krs_ctrl.sv */
`timescale 1ns / 1ps
module krs_ctrl import krs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  krs_req_t    req,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [14:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output krs_rsp_t    rsp,
	output krs_mon_t    mon
);

	krs_state_t state_q, state_nxt;
	krs_act_t   act_q;
	logic [63:0] key_q;
	logic [9:0]  len_q, flen_q, elen_q;
	logic        last_q;
	krs_status_t est_q;
	logic [11:0] pos_q, src_q, dst_q, end_q;
	logic [6:0]  stride_q, k_q, cnt_q, pidx_q;
	logic        pend_q;
	logic [14:0] free_q, cap_q;
	logic        ov_q;
	krs_rsp_t    rsp_q;

	// memory ports
	logic              m_we, m_re;
	logic [MemAw-1:0]  m_waddr, m_raddr;
	logic [63:0]       m_wdata, m_rdata;
	logic              g_we, g_re;
	logic [StageAw-1:0] g_waddr, g_raddr;
	logic [63:0]       g_rdata;

	krs_ram #(.Depth(MemWords), .Width(64)) u_rec (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
		.re(m_re), .raddr(m_raddr), .rdata(m_rdata)
	);

	krs_ram #(.Depth(StageWords), .Width(64)) u_stage (
		.clk(clk), .we(g_we), .waddr(g_waddr), .wdata(req.word),
		.re(g_re), .raddr(g_raddr), .rdata(g_rdata)
	);

	// derived values
	logic        acc, out_free, key_hit, at_end, copy_rd, copy_done;
	logic        pay_rd, pay_done, get_last;
	logic [10:0] len_p31;
	logic [6:0]  tot_w, put_nw, get_nw;
	logic [9:0]  tot_b;
	logic [14:0] cap_clamp;
	logic [63:0] get_word;
	logic [9:0]  byte_base;

	assign acc       = in_valid && in_ready;
	assign out_free  = !ov_q || out_ready;
	assign key_hit   = (m_rdata == key_q);
	assign at_end    = (pos_q >= end_q);
	assign copy_rd   = (src_q < end_q);
	assign copy_done = !copy_rd && !pend_q;
	assign len_p31   = {1'b0, len_q} + 11'd31;
	assign tot_w     = 7'(len_p31[10:3]) + 7'd1;
	assign tot_b     = {tot_w, 3'b000};
	assign put_nw    = 7'((len_q + 10'd7) >> 3);
	assign get_nw    = (flen_q == 10'd0) ? 7'd1 : 7'((flen_q + 10'd7) >> 3);
	assign pay_rd    = (k_q < put_nw);
	assign pay_done  = !pay_rd && !pend_q;
	assign get_last  = (k_q + 7'd1 == get_nw);
	assign cap_clamp = (cfg_data > MEM_BYTES) ? MEM_BYTES : cfg_data;
	assign byte_base = {k_q[5:0], 3'b000} + 10'd0;

	// byte mask of a payload word against the stored length
	always_comb begin
		for (int b = 0; b < 8; b++) begin
			get_word[8*b +: 8] = ((byte_base + 10'(b)) < flen_q) ? m_rdata[8*b +: 8] : 8'h00;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: if (acc) begin
				state_nxt = (req.action == ACT_PUT && !req.last) ? S_EMIT : S_SRCH;
			end
			S_SRCH: begin
				if (at_end) state_nxt = (act_q == ACT_PUT) ? S_CHK : S_EMIT;
				else        state_nxt = S_SKEY;
			end
			S_SKEY: state_nxt = key_hit ? S_HLEN : S_SSTR;
			S_SSTR: state_nxt = S_SRCH;
			S_HLEN: state_nxt = S_HSTR;
			S_HSTR: begin
				unique case (act_q)
					ACT_PUT, ACT_REM: state_nxt = S_COPY;
					ACT_GET:          state_nxt = S_GRD;
					default:          state_nxt = S_EMIT;
				endcase
			end
			S_COPY: if (copy_done) state_nxt = (act_q == ACT_PUT) ? S_CHK : S_EMIT;
			S_CHK: begin
				if (len_q > MAX_LEN || free_q < {5'd0, tot_b}) state_nxt = S_EMIT;
				else state_nxt = S_WHDR;
			end
			S_WHDR: if (k_q == 7'd2) state_nxt = S_WPAY;
			S_WPAY: if (pay_done) state_nxt = S_EMIT;
			S_GRD:  state_nxt = S_GOUT;
			S_GOUT: if (out_free) state_nxt = get_last ? S_IDLE : S_GRD;
			S_EMIT: if (out_free) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	// memory and handshake controls, a capacity write goes ahead of an input transfer
	always_comb begin
		in_ready  = (state_q == S_IDLE) && !cfg_valid;
		cfg_ready = (state_q == S_IDLE);
		m_we = 1'b0; m_re = 1'b0; m_waddr = '0; m_raddr = '0; m_wdata = '0;
		g_we = acc && req.action == ACT_PUT && cnt_q < 7'(StageWords);
		g_waddr = cnt_q[StageAw-1:0];
		g_re = 1'b0; g_raddr = k_q[StageAw-1:0];
		unique case (state_q)
			S_SRCH: begin
				m_re = !at_end; m_raddr = pos_q[MemAw-1:0];
			end
			S_SKEY: begin
				m_re = 1'b1;
				m_raddr = key_hit ? MemAw'(pos_q + 12'd1) : MemAw'(pos_q + 12'd2);
			end
			S_HLEN: begin
				m_re = 1'b1; m_raddr = MemAw'(pos_q + 12'd2);
			end
			S_COPY: begin
				m_re = copy_rd; m_raddr = src_q[MemAw-1:0];
				m_we = pend_q; m_waddr = dst_q[MemAw-1:0]; m_wdata = m_rdata;
			end
			S_WHDR: begin
				m_we = 1'b1; m_waddr = MemAw'(end_q + 12'(k_q));
				priority case (k_q)
					7'd0:    m_wdata = key_q;
					7'd1:    m_wdata = {54'd0, len_q};
					default: m_wdata = {54'd0, tot_b};
				endcase
			end
			S_WPAY: begin
				g_re = pay_rd;
				m_we = pend_q; m_waddr = dst_q[MemAw-1:0];
				m_wdata = (pidx_q < cnt_q) ? g_rdata : 64'd0;
			end
			S_GRD: begin
				m_re = 1'b1; m_raddr = MemAw'(pos_q + 12'd3 + 12'(k_q));
			end
			default: ;
		endcase
	end

	// state and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cap_q   <= CAP_RESET;
			end_q   <= START_W;
			free_q  <= CAP_RESET - START_B;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ov_q && out_ready) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						cap_q  <= cap_clamp;
						end_q  <= START_W;
						free_q <= (cap_clamp > START_B) ? cap_clamp - START_B : 15'd0;
						cnt_q  <= '0;
					end
					if (acc && g_we) cnt_q <= cnt_q + 7'd1;
				end
				S_SRCH: if (at_end) begin
					est_q <= ST_MISS; elen_q <= '0;
				end
				S_SSTR: pos_q <= pos_q + {5'd0, m_rdata[9:3]};
				S_HLEN: flen_q <= m_rdata[9:0];
				S_HSTR: begin
					stride_q <= m_rdata[9:3];
					src_q    <= pos_q + {5'd0, m_rdata[9:3]};
					dst_q    <= pos_q;
					pend_q   <= 1'b0;
					k_q      <= '0;
					est_q    <= ST_OK;
					elen_q   <= flen_q;
				end
				S_COPY: begin
					pend_q <= copy_rd;
					if (copy_rd) src_q <= src_q + 12'd1;
					if (pend_q) dst_q <= dst_q + 12'd1;
					if (copy_done) begin
						end_q  <= end_q - {5'd0, stride_q};
						free_q <= free_q + {5'd0, stride_q, 3'b000};
					end
				end
				S_CHK: begin
					est_q  <= ST_NOSPACE;
					elen_q <= '0;
					k_q    <= '0;
				end
				S_WHDR: begin
					k_q <= k_q + 7'd1;
					if (k_q == 7'd2) begin
						k_q    <= '0;
						pend_q <= 1'b0;
						dst_q  <= end_q + 12'd3;
					end
				end
				S_WPAY: begin
					pend_q <= pay_rd;
					pidx_q <= k_q;
					if (pay_rd) k_q <= k_q + 7'd1;
					if (pend_q) dst_q <= dst_q + 12'd1;
					if (pay_done) begin
						end_q  <= end_q + {5'd0, tot_w};
						free_q <= free_q - {5'd0, tot_b};
						est_q  <= ST_OK;
					end
				end
				S_GOUT: if (out_free) begin
					ov_q  <= 1'b1;
					rsp_q <= '{status: ST_OK, word: get_word, len: flen_q, last: get_last};
					k_q   <= k_q + 7'd1;
				end
				S_EMIT: if (out_free) begin
					ov_q  <= 1'b1;
					rsp_q <= '{status: est_q, word: 64'd0, len: elen_q, last: 1'b1};
					if (act_q == ACT_PUT && last_q) cnt_q <= '0;
				end
				default: ;
			endcase
			// input capture
			if (acc) begin
				act_q  <= krs_act_t'(req.action);
				key_q  <= req.key;
				len_q  <= req.len;
				last_q <= req.last;
				pos_q  <= START_W;
				est_q  <= ST_WORD;
				elen_q <= '0;
			end
		end
	end

	assign out_valid = ov_q;
	assign rsp       = rsp_q;
	assign mon       = '{idle: (state_q == S_IDLE), end_w: end_q, free_b: free_q, cap_b: cap_q};

endmodule

/* rtl/compacting_keyed_record_store.sv */
`timescale 1ns / 1ps
// channel   | direction | signals
// s_axis    | in        | s_tvalid s_tready s_tdata s_tuser(action) s_tlast(data_last)
// m_axis    | out       | m_tvalid m_tready m_tdata m_tuser(status) m_tlast(read_last)
// cfg       | in        | cfg_valid cfg_ready cfg_data (capacity_bytes)
//
// one item at a time; a non-final put word is only staged and then answered
// a lookup walks each record through the search, key and stride states, on the single read port of the record ram
// remove and put commit shift or write the words one at a time; get passes each word through a read and an output state
// reset empties the store by resetting its end pointer and free count; the record ram itself is not cleared
// output register lets a result wait on m_tready while the lookup finishes
module compacting_keyed_record_store import krs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [143:0] s_tdata,  // key[63:0], length_bytes[73:64], data_word[137:74], zero pad
	input  logic [1:0]   s_tuser,  // action
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [79:0]  m_tdata,  // read_word[63:0], read_length[73:64], zero pad
	output logic [1:0]   m_tuser,  // status
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [14:0]  cfg_data
);

	krs_req_t req;
	krs_rsp_t rsp;
	krs_mon_t mon;

	// unpack input transfer
	assign req = '{action: s_tuser, key: s_tdata[63:0], len: s_tdata[73:64],
		word: s_tdata[137:74], last: s_tlast};

	krs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready), .req(req),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.out_valid(m_tvalid), .out_ready(m_tready), .rsp(rsp), .mon(mon)
	);

	// pack result transfer
	assign m_tdata = {6'd0, rsp.len, rsp.word};
	assign m_tuser = rsp.status;
	assign m_tlast = rsp.last;

	// end pointer stays within the store
	a_end_range: assert property (@(posedge clk) disable iff (!arst_n)
		mon.end_w >= START_W && mon.end_w <= 12'(MemWords))
		else $error("end pointer out of range");

	// used plus free bytes equal the capacity past the header area
	a_space: assert property (@(posedge clk) disable iff (!arst_n)
		mon.cap_b >= START_B |->
		({mon.end_w, 3'b000} - START_B) + mon.free_b == mon.cap_b - START_B)
		else $error("space accounting broken");

	// one item at a time
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while busy");

	// ready only while idle
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> mon.idle)
		else $error("ready outside idle");

endmodule
